[rtl/vssi_pkg.sv]
package vssi_pkg;

  // Fixed-point format of every price, strike and register.
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SUM_W     = 48;
  localparam int unsigned INT_W     = SUM_W - FRAC_BITS;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [31:0] FORWARD_RESET = 32'd197533;
  localparam logic [31:0] SCALE_RESET   = 32'd9607520;

  // Configuration register indexes.
  localparam logic [7:0] CFG_FORWARD = 8'd0;
  localparam logic [7:0] CFG_SCALE   = 8'd1;

  typedef struct packed {
    logic [31:0] strike_price;
    logic [31:0] call_price;
    logic [31:0] put_price;
    logic        last_strike;
  } in_t;

  typedef struct packed {
    logic [31:0] volatility_strike;
    logic        overflow_flag;
  } out_t;

  // One interval contribution: price over the strike range [lo, hi].
  typedef struct packed {
    logic [31:0] price;
    logic [31:0] lo;
    logic [31:0] hi;
  } term_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic  has0;
    logic  has1;
    logic  last;
    term_t t0;
    term_t t1;
  } job_t;

  function automatic logic [31:0] half_sum(input logic [31:0] a, input logic [31:0] b);
    half_sum = (a >> 1) + (b >> 1) + {31'd0, a[0] & b[0]};
  endfunction

endpackage

[rtl/variance_swap_strike_integrator.sv]
// Variance swap fair strike by replication of an option strip.
// Input channel (in_valid_i/in_ready_o/in_i): one quote request per strike, in
// ascending strike order, with call and put price; last_strike closes the strip.
// Configuration channel (cfg_valid_i/cfg_ready_o): index 0 sets the forward
// price, index 1 the final scale; it is always ready, and the user must write
// it only while the block is idle, which the block does not enforce. Output
// channel (out_valid_o/out_ready_i/out_o): one result request, the Q16.16
// square root of the scaled integral, per strip. A front stage classifies each
// quote against the forward and queues up to two interval terms; the back
// stage evaluates them through one iterative divider. Each term is multiplied,
// checked, divided two quotient bits at a time and accumulated; a quote
// straddling the forward yields two terms. The last quote also adds scaling,
// a bit-serial square root and the output step. The input side keeps accepting
// into the two-entry queue, until it is full, while the back stage works.
// If the receiver stalls, the result stays in the output register and the
// back stage waits before loading the next one. Reset clears the history,
// the sum, the flag and the queue, and reloads the configuration defaults.
module variance_swap_strike_integrator import vssi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o
);

  logic [31:0] forward_q, scale_q;
  logic        push, full, pop, job_valid;
  job_t        job_in, job_out;

  // Registers take any write at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      forward_q <= FORWARD_RESET;
      scale_q   <= SCALE_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_FORWARD) forward_q <= cfg_data_i;
      if (cfg_index_i == CFG_SCALE)   scale_q   <= cfg_data_i;
    end
  end

  vssi_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .forward_i  (forward_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  vssi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .valid_o (job_valid)
  );

  vssi_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scale_i     (scale_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

[rtl/vssi_front.sv]
module vssi_front import vssi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] forward_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_i,
  output logic        push_o,
  output job_t        job_o,
  input  logic        full_i
);

  logic [31:0] prev_strike_q, prev_call_q, prev_put_q;
  logic        have_prev_q;
  logic        acc;
  logic [31:0] k, f, pm, cm;

  assign in_ready_o = !full_i;
  assign acc        = in_valid_i && in_ready_o;
  assign push_o     = acc;
  assign k          = in_i.strike_price;
  assign f          = forward_i;
  assign pm         = half_sum(prev_put_q, in_i.put_price);
  assign cm         = half_sum(prev_call_q, in_i.call_price);

  always_comb begin
    job_o      = '0;
    job_o.has0 = have_prev_q;
    job_o.last = in_i.last_strike;
    if (prev_strike_q < f && k < f) begin
      job_o.t0 = '{price: pm, lo: prev_strike_q, hi: k};
    end else if (prev_strike_q < f) begin
      // Interval straddles the forward: split it there.
      job_o.t0   = '{price: half_sum(pm, prev_put_q), lo: prev_strike_q, hi: f};
      job_o.t1   = '{price: half_sum(cm, in_i.call_price), lo: f, hi: k};
      job_o.has1 = have_prev_q;
    end else begin
      job_o.t0 = '{price: cm, lo: prev_strike_q, hi: k};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_strike_q <= '0;
      prev_call_q   <= '0;
      prev_put_q    <= '0;
      have_prev_q   <= 1'b0;
    end else if (acc) begin
      if (in_i.last_strike) begin
        prev_strike_q <= '0;
        prev_call_q   <= '0;
        prev_put_q    <= '0;
        have_prev_q   <= 1'b0;
      end else begin
        prev_strike_q <= k;
        prev_call_q   <= in_i.call_price;
        prev_put_q    <= in_i.put_price;
        have_prev_q   <= 1'b1;
      end
    end
  end

endmodule

[rtl/vssi_fifo.sv]
module vssi_fifo import vssi_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic full_o,
  input  logic pop_i,
  output job_t data_o,
  output logic valid_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  a_no_overfill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i)) else $error("push into full queue");
  a_no_underrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count out of range");

endmodule

[rtl/vssi_back.sv]
module vssi_back import vssi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [31:0] scale_i,
  input  logic        job_valid_i,
  input  job_t        job_i,
  output logic        job_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_CHK  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_ACC  = 4'd4;
  localparam logic [3:0] ST_SC1  = 4'd5;
  localparam logic [3:0] ST_SC2  = 4'd6;
  localparam logic [3:0] ST_SQ   = 4'd7;
  localparam logic [3:0] ST_OUT  = 4'd8;

  localparam logic [4:0] DIV_LAST = 5'(SUM_W / 2 - 1);

  logic [3:0]       state_q, state_d;
  logic             tsel_q, tsel_d;
  logic [63:0]      num_q, num_d, den_q, den_d;
  logic [64:0]      rem_q, rem_d;
  logic [SUM_W-1:0] dv_q, dv_d, quo_q, quo_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic             sat_q, sat_d;
  logic [63:0]      plo_q, plo_d;
  logic [47:0]      phi_q, phi_d;
  logic [63:0]      sv_q, sv_d;
  logic [35:0]      srem_q, srem_d;
  logic [31:0]      root_q, root_d;
  logic             ovalid_q, ovalid_d;
  out_t             out_q, out_d;
  logic             pop;

  term_t            t;
  logic [SUM_W:0]   sum_ext;
  logic [79:0]      prod;
  logic [64:0]      r;
  logic [SUM_W-1:0] dv, q;
  logic [35:0]      sr, trial;

  assign t         = tsel_q ? job_i.t1 : job_i.t0;
  assign job_pop_o = pop;
  assign out_valid_o = ovalid_q;
  assign out_o     = out_q;
  assign sum_ext   = {1'b0, sum_q} + {1'b0, quo_q};
  assign prod      = {phi_q, 32'd0} + {16'd0, plo_q};

  always_comb begin
    state_d  = state_q;
    tsel_d   = tsel_q;
    num_d    = num_q;
    den_d    = den_q;
    rem_d    = rem_q;
    dv_d     = dv_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    sum_d    = sum_q;
    sat_d    = sat_q;
    plo_d    = plo_q;
    phi_d    = phi_q;
    sv_d     = sv_q;
    srem_d   = srem_q;
    root_d   = root_q;
    ovalid_d = ovalid_q && !out_ready_i;
    out_d    = out_q;
    pop      = 1'b0;
    r        = rem_q;
    dv       = dv_q;
    q        = quo_q;
    sr       = '0;
    trial    = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          tsel_d = 1'b0;
          if (job_i.has0) begin
            state_d = ST_MUL;
          end else if (job_i.last) begin
            state_d = ST_SC1;
          end else begin
            pop = 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (t.hi <= t.lo) begin
          // Empty or descending interval adds nothing.
          if (!tsel_q && job_i.has1) begin
            tsel_d = 1'b1;
          end else if (job_i.last) begin
            state_d = ST_SC1;
          end else begin
            pop     = 1'b1;
            state_d = ST_IDLE;
          end
        end else begin
          num_d   = {32'd0, t.price} * {32'd0, t.hi - t.lo};
          den_d   = {32'd0, half_sum(t.lo, t.hi)} * {32'd0, half_sum(t.lo, t.hi)};
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (num_q == '0) begin
          quo_d   = '0;
          state_d = ST_ACC;
        end else if (den_q == '0 || (num_q >> INT_W) >= den_q) begin
          quo_d   = SUM_MAX;
          sat_d   = 1'b1;
          state_d = ST_ACC;
        end else begin
          rem_d   = {1'b0, num_q >> INT_W};
          dv_d    = {num_q[INT_W-1:0], {FRAC_BITS{1'b0}}};
          quo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        // Two restoring quotient bits per cycle.
        for (int i = 0; i < 2; i++) begin
          r  = {r[63:0], dv[SUM_W-1]};
          dv = dv << 1;
          q  = q << 1;
          if (r >= {1'b0, den_q}) begin
            r    = r - {1'b0, den_q};
            q[0] = 1'b1;
          end
        end
        rem_d = r;
        dv_d  = dv;
        quo_d = q;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == DIV_LAST) state_d = ST_ACC;
      end
      ST_ACC: begin
        if (sum_ext[SUM_W]) begin
          sum_d = SUM_MAX;
          sat_d = 1'b1;
        end else begin
          sum_d = sum_ext[SUM_W-1:0];
        end
        if (!tsel_q && job_i.has1) begin
          tsel_d  = 1'b1;
          state_d = ST_MUL;
        end else if (job_i.last) begin
          state_d = ST_SC1;
        end else begin
          pop     = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SC1: begin
        plo_d   = {32'd0, sum_q[31:0]} * {32'd0, scale_i};
        phi_d   = {32'd0, sum_q[47:32]} * {16'd0, scale_i};
        state_d = ST_SC2;
      end
      ST_SC2: begin
        if (prod[79:64] != '0) begin
          root_d  = '1;
          sat_d   = 1'b1;
          state_d = ST_OUT;
        end else begin
          sv_d    = prod[63:0];
          srem_d  = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        sr    = {srem_q[33:0], sv_q[63:62]};
        trial = {2'b00, root_q, 2'b01};
        sv_d  = sv_q << 2;
        if (sr >= trial) begin
          srem_d = sr - trial;
          root_d = {root_q[30:0], 1'b1};
        end else begin
          srem_d = sr;
          root_d = {root_q[30:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd31) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!ovalid_q) begin
          ovalid_d = 1'b1;
          out_d    = '{volatility_strike: root_q, overflow_flag: sat_q};
          sum_d    = '0;
          sat_d    = 1'b0;
          pop      = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    den_q  <= den_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    quo_q  <= quo_d;
    plo_q  <= plo_d;
    phi_q  <= phi_d;
    sv_q   <= sv_d;
    srem_q <= srem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tsel_q   <= 1'b0;
      cnt_q    <= '0;
      sum_q    <= '0;
      sat_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      tsel_q   <= tsel_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      sat_q    <= sat_d;
      ovalid_q <= ovalid_d;
    end
  end

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> rem_q < {1'b0, den_q}) else $error("divider remainder too large");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> job_valid_i) else $error("job popped while queue empty");
  a_sq_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SQ |=> (state_q == ST_SQ || state_q == ST_OUT))
    else $error("root sequence left early");

endmodule
